// ----- rtl/core/sfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Snapshot file parser package
// Shared types, opcodes and encodings of the snapshot file stream parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Parser sections.
  typedef enum logic [3:0] {
    S_HEADER    = 4'd0,
    S_TOP       = 4'd1,
    S_AFTER_DB  = 4'd2,
    S_KEYS      = 4'd3,
    S_TYPE      = 4'd4,
    S_STR_LEN   = 4'd5,
    S_STR_BYTES = 4'd6,
    S_SIZE_LEN  = 4'd7,
    S_BE        = 4'd8,
    S_LE        = 4'd9,
    S_DONE      = 4'd10,
    S_ERROR     = 4'd11
  } sec_e;

  // Token kinds, also used as the current field.
  typedef enum logic [3:0] {
    K_AUX_KEY    = 4'd0,
    K_AUX_VALUE  = 4'd1,
    K_DB_INDEX   = 4'd2,
    K_KEY_SIZE   = 4'd3,
    K_EXP_SIZE   = 4'd4,
    K_EXPIRY     = 4'd5,
    K_KEY        = 4'd6,
    K_VALUE      = 4'd7,
    K_END        = 4'd8,
    K_ERROR      = 4'd9
  } kind_e;

  // Error codes carried in the payload of an error token.
  localparam logic [1:0] ERR_TYPE    = 2'd0;
  localparam logic [1:0] ERR_STR_ENC = 2'd1;
  localparam logic [1:0] ERR_SIZE_ENC = 2'd2;

  // Opcodes and encodings.
  localparam logic [7:0] OP_AUX       = 8'hFA;
  localparam logic [7:0] OP_SELECTDB  = 8'hFE;
  localparam logic [7:0] OP_RESIZEDB  = 8'hFB;
  localparam logic [7:0] OP_EOF       = 8'hFF;
  localparam logic [7:0] OP_EXPIRE_S  = 8'hFC;
  localparam logic [7:0] OP_EXPIRE_MS = 8'hFD;
  localparam logic [7:0] ENC_INT8     = 8'hC0;
  localparam logic [7:0] ENC_INT16    = 8'hC1;
  localparam logic [7:0] ENC_INT32    = 8'hC2;
  localparam logic [7:0] SIZE_32      = 8'h80;
  localparam logic [7:0] SIZE_64      = 8'h81;
  localparam logic [5:0] LEN_MASK     = 6'h3F;

  localparam logic [9:0] MS_PER_S      = 10'd1000;
  localparam logic [7:0] HDR_LEN_RESET = 8'd9;

  // Register addresses.
  localparam logic [2:0] REG_HEADER_LENGTH = 3'd0;

  // One accepted input byte.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       start_of_file;
  } in_item_t;

  // One result token.
  typedef struct packed {
    kind_e       token_kind;
    logic [63:0] payload;
    logic        is_integer;
    logic        field_end;
    logic        is_empty;
  } res_item_t;

endpackage

// ----- rtl/core/snapshot_file_stream_parser_unit.sv -----
// ----------------------------------------------------------------------------
// Snapshot file stream parser
// Turns a key-value snapshot file, one byte per request, into tokens.
// ----------------------------------------------------------------------------
// The parser takes one file byte per clock cycle and can take a new byte in
// every cycle while no token waits on the output; a token is presented on
// the output stream once its byte has passed the input register and the
// next-state logic has fed the result register. Rate is set by the parser
// state update, which also holds the seconds-to-milliseconds multiply of a
// 32-bit expiry. A token that waits on the output holds the parser, so the
// input stops after one further byte. Bytes that produce no token (header
// bytes, opcodes, length and integer bytes) are absorbed without output. A
// byte with tuser high restarts the parser; the header length register
// (reset 9) sets how many leading bytes are skipped.
module snapshot_file_stream_parser_unit
  import sfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic        s_axis_tuser,   // [0] start_of_file
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] payload
  output logic        m_axis_tlast,   // field_end
  output logic [5:0]  m_axis_tuser    // [3:0] token_kind, [4] is_integer, [5] is_empty
);

  logic [7:0] header_length;
  in_item_t   in_item;
  in_item_t   item;
  logic       item_valid;
  logic       item_take;
  res_item_t  res;

  sfp_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .header_length_o (header_length)
  );

  assign in_item = '{byte_value: s_axis_tdata, start_of_file: s_axis_tuser};

  sfp_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  sfp_parse_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .header_length_i (header_length),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_take_o     (item_take),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_o           (res)
  );

  assign m_axis_tdata = res.payload;
  assign m_axis_tlast = res.field_end;
  assign m_axis_tuser = {res.is_empty, res.is_integer, res.token_kind};

endmodule

// ----- rtl/core/sfp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Snapshot file parser configuration registers
// APB-style register port holding the header length.
// ----------------------------------------------------------------------------
module sfp_cfg_regs
  import sfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  header_length_o
);

  logic [7:0] hdr_len_q;
  logic [7:0] hdr_len_d;
  logic       hit;

  assign pready = 1'b1;
  assign hit    = (paddr == REG_HEADER_LENGTH);

  always_comb begin
    hdr_len_d = hdr_len_q;
    if (psel && penable && pwrite && hit) begin
      hdr_len_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_len_q <= HDR_LEN_RESET;
    end else begin
      hdr_len_q <= hdr_len_d;
    end
  end

  assign prdata          = hit ? {24'd0, hdr_len_q} : 32'd0;
  assign header_length_o = hdr_len_q;

endmodule

// ----- rtl/core/sfp_in_reg.sv -----
// ----------------------------------------------------------------------------
// Snapshot file parser input register
// Captures one input byte request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module sfp_in_reg
  import sfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     item_valid_o,
  input  logic     item_take_i,
  output in_item_t item_o
);

  logic     valid_q;
  logic     valid_d;
  in_item_t item_q;
  logic     load;

  // The register refills in the same cycle in which the parser takes it.
  assign in_ready_o = !valid_q || item_take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (item_take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- rtl/core/sfp_parse_core.sv -----
// ----------------------------------------------------------------------------
// Snapshot file parser core
// Parser state, per-byte next-state logic and the result register.
// ----------------------------------------------------------------------------
module sfp_parse_core
  import sfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] header_length_i,
  input  logic       item_valid_i,
  input  in_item_t   item_i,
  output logic       item_take_o,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output res_item_t  res_o
);

  typedef struct packed {
    sec_e       sec;
    kind_e      cf;
    logic [1:0] sfl;
  } next_fld_t;

  sec_e        sec_q,  sec_d,  sec,  cur;
  logic [7:0]  hc_q,   hc_d,   hc;
  logic [3:0]  bc_q,   bc_d,   bc,   bc_n;
  logic [63:0] acc_q,  acc_d,  acc,  acc_n, acc_or, acc_sx;
  logic [63:0] pexp_q, pexp_d, pexp;
  logic [5:0]  srem_q, srem_d, srem, srem_n;
  kind_e       cf_q,   cf_d,   cf;
  logic [1:0]  sfl_q,  sfl_d,  sfl;
  logic [7:0]  b;
  logic        key_ok, adb_ok, top_ok;
  logic        has_res;
  res_item_t   res_d;
  res_item_t   res_q;
  logic        res_valid_q;
  logic        res_valid_d;
  next_fld_t   nf;
  logic [41:0] exp_ms;

  // What follows a completed field.
  function automatic next_fld_t field_done(kind_e f, logic [1:0] s);
    next_fld_t  r;
    logic [1:0] s_n;
    r     = '{sec: S_KEYS, cf: f, sfl: s};
    s_n   = s - {1'b0, (s != 2'd0)};
    unique case (f)
      K_AUX_KEY: begin
        r.cf  = K_AUX_VALUE;
        r.sec = S_STR_LEN;
      end
      K_AUX_VALUE: r.sec = S_TOP;
      K_DB_INDEX:  r.sec = S_AFTER_DB;
      K_KEY_SIZE, K_EXP_SIZE: begin
        r.sfl = s_n;
        if (s_n != 2'd0) begin
          r.cf  = K_EXP_SIZE;
          r.sec = S_SIZE_LEN;
        end
      end
      K_KEY: begin
        r.cf  = K_VALUE;
        r.sec = S_STR_LEN;
      end
      default: r.sec = S_KEYS;
    endcase
    return r;
  endfunction

  assign item_take_o = item_valid_i && (!res_valid_q || res_ready_i);
  assign b           = item_i.byte_value;

  // Start of file clears the state before the byte is looked at.
  always_comb begin
    if (item_i.start_of_file) begin
      sec  = S_HEADER;
      hc   = 8'd0;
      bc   = 4'd0;
      acc  = 64'd0;
      pexp = '1;
      srem = 6'd0;
      cf   = K_AUX_KEY;
      sfl  = 2'd0;
    end else begin
      sec  = sec_q;
      hc   = hc_q;
      bc   = bc_q;
      acc  = acc_q;
      pexp = pexp_q;
      srem = srem_q;
      cf   = cf_q;
      sfl  = sfl_q;
    end
  end

  assign cur    = (sec == S_HEADER) ? S_TOP : sec;
  assign top_ok = (cur == S_TOP);
  assign adb_ok = top_ok || (cur == S_AFTER_DB);
  assign key_ok = adb_ok || (cur == S_KEYS);

  assign srem_n = srem - {5'd0, (srem != 6'd0)};
  assign bc_n   = (cur == S_LE) ? (bc + 4'd1) : (bc - {3'd0, (bc != 4'd0)});
  assign acc_n  = {acc[55:0], b};
  assign acc_or = acc | ({56'd0, b} << {bc[2:0], 3'b000});
  assign exp_ms = {10'd0, acc_or[31:0]} * {32'd0, MS_PER_S};

  always_comb begin
    unique case (srem)
      6'd1:    acc_sx = {{56{acc_or[7]}},  acc_or[7:0]};
      6'd2:    acc_sx = {{48{acc_or[15]}}, acc_or[15:0]};
      6'd4:    acc_sx = {{32{acc_or[31]}}, acc_or[31:0]};
      default: acc_sx = acc_or;
    endcase
  end

  always_comb begin
    sec_d   = sec;
    hc_d    = hc;
    bc_d    = bc;
    acc_d   = acc;
    pexp_d  = pexp;
    srem_d  = srem;
    cf_d    = cf;
    sfl_d   = sfl;
    has_res = 1'b0;
    res_d   = '{token_kind: cf, payload: 64'd0, is_integer: 1'b0,
                field_end: 1'b1, is_empty: 1'b0};
    nf      = field_done(cf, sfl);

    if (sec == S_HEADER && hc < header_length_i) begin
      hc_d = hc + 8'd1;
    end else begin
      sec_d = cur;
      priority if (top_ok && b == OP_AUX) begin
        cf_d  = K_AUX_KEY;
        sec_d = S_STR_LEN;
      end else if (top_ok && b == OP_SELECTDB) begin
        cf_d  = K_DB_INDEX;
        sec_d = S_SIZE_LEN;
      end else if (adb_ok && b == OP_RESIZEDB) begin
        sfl_d = 2'd2;
        cf_d  = K_KEY_SIZE;
        sec_d = S_SIZE_LEN;
      end else if (key_ok && b == OP_EOF) begin
        sec_d            = S_DONE;
        has_res          = 1'b1;
        res_d.token_kind = K_END;
      end else if (key_ok && (b == OP_EXPIRE_S || b == OP_EXPIRE_MS)) begin
        cf_d   = K_EXPIRY;
        acc_d  = 64'd0;
        bc_d   = 4'd0;
        srem_d = (b == OP_EXPIRE_S) ? 6'd4 : 6'd8;
        sec_d  = S_LE;
      end else if (key_ok || cur == S_TYPE) begin
        has_res = 1'b1;
        if (b != 8'd0) begin
          sec_d            = S_ERROR;
          res_d.token_kind = K_ERROR;
          res_d.payload    = {62'd0, ERR_TYPE};
        end else begin
          res_d.token_kind = K_EXPIRY;
          res_d.payload    = pexp;
          res_d.is_integer = 1'b1;
          pexp_d           = '1;
          cf_d             = K_KEY;
          sec_d            = S_STR_LEN;
        end
      end else begin
        unique case (cur)
          S_STR_LEN: begin
            if (b[7:6] == 2'b00) begin
              srem_d = b[5:0] & LEN_MASK;
              if (b[5:0] == 6'd0) begin
                has_res        = 1'b1;
                res_d.is_empty = 1'b1;
                sec_d          = nf.sec;
                cf_d           = nf.cf;
                sfl_d          = nf.sfl;
              end else begin
                sec_d = S_STR_BYTES;
              end
            end else if (b == ENC_INT8 || b == ENC_INT16 || b == ENC_INT32) begin
              acc_d  = 64'd0;
              bc_d   = 4'd0;
              srem_d = (b == ENC_INT8) ? 6'd1 : ((b == ENC_INT16) ? 6'd2 : 6'd4);
              sec_d  = S_LE;
            end else begin
              sec_d            = S_ERROR;
              has_res          = 1'b1;
              res_d.token_kind = K_ERROR;
              res_d.payload    = {62'd0, ERR_STR_ENC};
            end
          end
          S_STR_BYTES: begin
            srem_d          = srem_n;
            has_res         = 1'b1;
            res_d.payload   = {56'd0, b};
            res_d.field_end = (srem_n == 6'd0);
            if (srem_n == 6'd0) begin
              sec_d = nf.sec;
              cf_d  = nf.cf;
              sfl_d = nf.sfl;
            end
          end
          S_SIZE_LEN: begin
            if (b[7:6] == 2'b00) begin
              has_res          = 1'b1;
              res_d.payload    = {56'd0, b};
              res_d.is_integer = 1'b1;
              sec_d            = nf.sec;
              cf_d             = nf.cf;
              sfl_d            = nf.sfl;
            end else if (b[7:6] == 2'b01) begin
              acc_d = {58'd0, b[5:0]};
              bc_d  = 4'd1;
              sec_d = S_BE;
            end else if (b == SIZE_32 || b == SIZE_64) begin
              acc_d = 64'd0;
              bc_d  = (b == SIZE_32) ? 4'd4 : 4'd8;
              sec_d = S_BE;
            end else if (b == ENC_INT8 || b == ENC_INT16 || b == ENC_INT32) begin
              acc_d  = 64'd0;
              bc_d   = 4'd0;
              srem_d = (b == ENC_INT8) ? 6'd1 : ((b == ENC_INT16) ? 6'd2 : 6'd4);
              sec_d  = S_LE;
            end else begin
              sec_d            = S_ERROR;
              has_res          = 1'b1;
              res_d.token_kind = K_ERROR;
              res_d.payload    = {62'd0, ERR_SIZE_ENC};
            end
          end
          S_BE: begin
            acc_d = acc_n;
            bc_d  = bc_n;
            if (bc_n == 4'd0) begin
              has_res          = 1'b1;
              res_d.payload    = acc_n;
              res_d.is_integer = 1'b1;
              sec_d            = nf.sec;
              cf_d             = nf.cf;
              sfl_d            = nf.sfl;
            end
          end
          S_LE: begin
            acc_d = acc_or;
            bc_d  = bc_n;
            if ({2'd0, bc_n} >= srem) begin
              if (cf == K_EXPIRY) begin
                pexp_d = (srem == 6'd4) ? {22'd0, exp_ms} : acc_or;
                sec_d  = S_TYPE;
              end else begin
                acc_d            = acc_sx;
                has_res          = 1'b1;
                res_d.payload    = acc_sx;
                res_d.is_integer = 1'b1;
                sec_d            = nf.sec;
                cf_d             = nf.cf;
                sfl_d            = nf.sfl;
              end
            end
          end
          default: begin
            // Finished or failed files ignore bytes until the next start.
            sec_d = cur;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q  <= S_HEADER;
      hc_q   <= 8'd0;
      bc_q   <= 4'd0;
      acc_q  <= 64'd0;
      pexp_q <= '1;
      srem_q <= 6'd0;
      cf_q   <= K_AUX_KEY;
      sfl_q  <= 2'd0;
    end else if (item_take_o) begin
      sec_q  <= sec_d;
      hc_q   <= hc_d;
      bc_q   <= bc_d;
      acc_q  <= acc_d;
      pexp_q <= pexp_d;
      srem_q <= srem_d;
      cf_q   <= cf_d;
      sfl_q  <= sfl_d;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (item_take_o) begin
      res_valid_d = has_res;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o && has_res) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  // An error token always leaves the parser in the error section.
  a_err_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && has_res && res_d.token_kind == K_ERROR |=> sec_q == S_ERROR)
    else $error("error token did not move the parser to the error section");

  // An empty string token is a closed, non-integer field.
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.is_empty |-> res_q.field_end && !res_q.is_integer)
    else $error("empty string token with bad flags");

  // String byte section always has bytes left to take.
  a_str_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q == S_STR_BYTES |-> srem_q != 6'd0)
    else $error("string byte section with nothing left");

  // A little-endian integer is never past its length.
  a_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q == S_LE |-> {2'd0, bc_q} < srem_q)
    else $error("little-endian byte count past its length");
`endif

endmodule

// ----- verif/snapshot_file_stream_parser_unit_test.sv -----
// ----------------------------------------------------------------------------
// Snapshot file stream parser testbench
// Drives snapshot files one byte per request into the parser, shadows the
// parser in a behavioral copy and checks every token it emits. A short table
// of hand-picked bytes comes first. Random files follow: well-formed ones,
// broken ones and noise, under several header lengths, with random gaps on
// the input side and stalls on the output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module snapshot_file_stream_parser_unit_test;
  import sfp_pkg::*;

  localparam int         CYCLE_LIMIT = 500000;
  localparam logic [7:0] TYPE_STRING = 8'h00;

  typedef struct {
    in_item_t  item;
    logic      typed;
    logic      has_tok;
    res_item_t tok;
  } stim_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [5:0]  m_axis_tuser;

  snapshot_file_stream_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the parser state.
  sec_e        p_sec;
  logic [7:0]  p_hdr_len;
  logic [7:0]  p_hdr_cnt;
  logic [3:0]  p_cnt;
  logic [63:0] p_acc;
  logic [63:0] p_exp;
  logic [5:0]  p_rem;
  kind_e       p_field;
  logic [1:0]  p_sizes_left;

  res_item_t   due_tokens[$];
  stim_t       stim_q[$];
  logic        next_sof;
  int          n_fail;
  int          cycles;

  function automatic void note_fail(string msg);
    n_fail++;
    if (n_fail <= 10) $display("%s", msg);
  endfunction

  function automatic void clear_parser();
    p_sec        = S_HEADER;
    p_hdr_cnt    = '0;
    p_cnt        = '0;
    p_acc        = '0;
    p_exp        = '1;
    p_rem        = '0;
    p_field      = K_AUX_KEY;
    p_sizes_left = '0;
  endfunction

  function automatic res_item_t mk_tok(kind_e k, logic [63:0] pl, logic ii, logic fe,
                                       logic em);
    res_item_t t;
    t.token_kind = k;
    t.payload    = pl;
    t.is_integer = ii;
    t.field_end  = fe;
    t.is_empty   = em;
    return t;
  endfunction

  function automatic void begin_le(logic [5:0] n);
    p_acc = '0;
    p_cnt = '0;
    p_rem = n;
    p_sec = S_LE;
  endfunction

  function automatic logic [5:0] int_width(logic [7:0] b);
    case (b)
      ENC_INT8:  return 6'd1;
      ENC_INT16: return 6'd2;
      ENC_INT32: return 6'd4;
      default:   return 6'd0;
    endcase
  endfunction

  // Pick the section that follows a completed field.
  function automatic void next_field();
    case (p_field)
      K_AUX_KEY: begin
        p_field = K_AUX_VALUE;
        p_sec   = S_STR_LEN;
      end
      K_AUX_VALUE: p_sec = S_TOP;
      K_DB_INDEX:  p_sec = S_AFTER_DB;
      K_KEY_SIZE, K_EXP_SIZE: begin
        if (p_sizes_left != 0) p_sizes_left = p_sizes_left - 1'b1;
        if (p_sizes_left != 0) begin
          p_field = K_EXP_SIZE;
          p_sec   = S_SIZE_LEN;
        end else begin
          p_sec = S_KEYS;
        end
      end
      K_KEY: begin
        p_field = K_VALUE;
        p_sec   = S_STR_LEN;
      end
      default: p_sec = S_KEYS;
    endcase
  endfunction

  // Advances the shadow parser by one byte; returns 1 when a token results.
  function automatic logic parse_byte(input in_item_t it, output res_item_t tok);
    logic [7:0]  b;
    logic [63:0] m;
    logic [5:0]  w;
    kind_e       k;
    b   = it.byte_value;
    tok = '0;
    if (it.start_of_file) clear_parser();
    if (p_sec == S_HEADER) begin
      if (p_hdr_cnt < p_hdr_len) begin
        p_hdr_cnt = p_hdr_cnt + 1'b1;
        return 1'b0;
      end
      p_sec = S_TOP;
    end
    k = p_field;
    w = int_width(b);
    case (p_sec)
      S_TOP, S_AFTER_DB, S_KEYS, S_TYPE: begin
        if (p_sec == S_TOP && b == OP_AUX) begin
          p_field = K_AUX_KEY;
          p_sec   = S_STR_LEN;
        end else if (p_sec == S_TOP && b == OP_SELECTDB) begin
          p_field = K_DB_INDEX;
          p_sec   = S_SIZE_LEN;
        end else if (p_sec inside {S_TOP, S_AFTER_DB} && b == OP_RESIZEDB) begin
          p_sizes_left = 2'd2;
          p_field      = K_KEY_SIZE;
          p_sec        = S_SIZE_LEN;
        end else if (p_sec != S_TYPE && b == OP_EOF) begin
          p_sec = S_DONE;
          tok   = mk_tok(K_END, '0, 1'b0, 1'b1, 1'b0);
          return 1'b1;
        end else if (p_sec != S_TYPE && (b == OP_EXPIRE_S || b == OP_EXPIRE_MS)) begin
          p_field = K_EXPIRY;
          begin_le((b == OP_EXPIRE_S) ? 6'd4 : 6'd8);
        end else if (b != TYPE_STRING) begin
          p_sec = S_ERROR;
          tok   = mk_tok(K_ERROR, 64'(ERR_TYPE), 1'b0, 1'b1, 1'b0);
          return 1'b1;
        end else begin
          // The type byte of every record carries the expiry, -1 when none.
          tok     = mk_tok(K_EXPIRY, p_exp, 1'b1, 1'b1, 1'b0);
          p_exp   = '1;
          p_field = K_KEY;
          p_sec   = S_STR_LEN;
          return 1'b1;
        end
        return 1'b0;
      end
      S_STR_LEN: begin
        if (b[7:6] == 2'b00) begin
          p_rem = b[5:0];
          if (p_rem == 0) begin
            next_field();
            tok = mk_tok(k, '0, 1'b0, 1'b1, 1'b1);
            return 1'b1;
          end
          p_sec = S_STR_BYTES;
          return 1'b0;
        end
        if (w != 0) begin
          begin_le(w);
          return 1'b0;
        end
        p_sec = S_ERROR;
        tok   = mk_tok(K_ERROR, 64'(ERR_STR_ENC), 1'b0, 1'b1, 1'b0);
        return 1'b1;
      end
      S_STR_BYTES: begin
        if (p_rem != 0) p_rem = p_rem - 1'b1;
        tok = mk_tok(k, 64'(b), 1'b0, p_rem == 0, 1'b0);
        if (p_rem == 0) next_field();
        return 1'b1;
      end
      S_SIZE_LEN: begin
        if (b[7:6] == 2'b00) begin
          next_field();
          tok = mk_tok(k, 64'(b), 1'b1, 1'b1, 1'b0);
          return 1'b1;
        end
        if (b[7:6] == 2'b01) begin
          p_acc = 64'(b[5:0]);
          p_cnt = 4'd1;
          p_sec = S_BE;
          return 1'b0;
        end
        if (b == SIZE_32 || b == SIZE_64) begin
          p_acc = '0;
          p_cnt = (b == SIZE_32) ? 4'd4 : 4'd8;
          p_sec = S_BE;
          return 1'b0;
        end
        if (w != 0) begin
          begin_le(w);
          return 1'b0;
        end
        p_sec = S_ERROR;
        tok   = mk_tok(K_ERROR, 64'(ERR_SIZE_ENC), 1'b0, 1'b1, 1'b0);
        return 1'b1;
      end
      S_BE: begin
        p_acc = {p_acc[55:0], b};
        if (p_cnt != 0) p_cnt = p_cnt - 1'b1;
        if (p_cnt != 0) return 1'b0;
        next_field();
        tok = mk_tok(k, p_acc, 1'b1, 1'b1, 1'b0);
        return 1'b1;
      end
      S_LE: begin
        p_acc = p_acc | (64'(b) << (8 * p_cnt[2:0]));
        p_cnt = p_cnt + 1'b1;
        if (6'(p_cnt) < p_rem) return 1'b0;
        if (p_field == K_EXPIRY) begin
          p_exp = (p_rem == 6'd4) ? p_acc * 64'(MS_PER_S) : p_acc;
          p_sec = S_TYPE;
          return 1'b0;
        end
        // Sign-extend the short integer encodings.
        if (p_rem >= 1 && p_rem < 8) begin
          m     = 64'd1 << (8 * p_rem - 1);
          p_acc = (p_acc ^ m) - m;
        end
        next_field();
        tok = mk_tok(k, p_acc, 1'b1, 1'b1, 1'b0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Stimulus building.
  function automatic void row(logic [7:0] b, logic sof);
    stim_t s;
    s.item.byte_value    = b;
    s.item.start_of_file = sof;
    s.typed              = 1'b0;
    s.has_tok            = 1'b0;
    s.tok                = '0;
    stim_q.push_back(s);
  endfunction

  function automatic void row_tok(logic [7:0] b, logic sof, logic has, kind_e k,
                                  logic [63:0] pl, logic ii, logic fe, logic em);
    row(b, sof);
    stim_q[$].typed   = 1'b1;
    stim_q[$].has_tok = has;
    stim_q[$].tok     = mk_tok(k, pl, ii, fe, em);
  endfunction

  function automatic void put(logic [7:0] b);
    row(b, next_sof);
    next_sof = 1'b0;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(8'hF8, 8'hFF));
      1:       return 8'($urandom_range(8'h7E, 8'hC3));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_string();
    int sel;
    int n;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      n = (sel == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
      put(8'(n));
      repeat (n) put(8'($urandom));
    end else begin
      n = (sel == 6) ? 1 : (sel == 7) ? 2 : 4;
      put((n == 1) ? ENC_INT8 : (n == 2) ? ENC_INT16 : ENC_INT32);
      repeat (n) put(8'($urandom));
    end
  endfunction

  function automatic void put_size();
    case ($urandom_range(0, 9))
      4, 5: begin
        put(8'($urandom_range(8'h40, 8'h7F)));
        put(8'($urandom));
      end
      6: begin
        put(SIZE_32);
        repeat (4) put(8'($urandom));
      end
      7: begin
        put(SIZE_64);
        repeat (8) put(8'($urandom));
      end
      8: begin
        put(8'($urandom_range(ENC_INT8, ENC_INT32)));
        repeat (4) put(8'($urandom));
      end
      default: put(8'($urandom_range(0, 63)));
    endcase
  endfunction

  // Appends one file; returns the number of bytes behind the header.
  function automatic int put_file(int hl);
    int mark;
    int kind;
    int recs;
    int bad_rec;
    next_sof = 1'b1;
    repeat (hl) put(8'($urandom));
    mark = stim_q.size();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(4, 30)) put(noise_byte());
    end else begin
      repeat ($urandom_range(0, 2)) begin
        put(OP_AUX);
        put_string();
        put_string();
      end
      if ($urandom_range(0, 1)) begin
        put(OP_SELECTDB);
        put_size();
      end
      if ($urandom_range(0, 1)) begin
        put(OP_RESIZEDB);
        put_size();
        put_size();
      end
      recs    = $urandom_range(0, 4);
      bad_rec = (kind == 1) ? $urandom_range(0, recs) : -1;
      for (int r = 0; r < recs; r++) begin
        case ($urandom_range(0, 2))
          0: begin
            put(OP_EXPIRE_S);
            repeat (4) put(8'($urandom));
          end
          1: begin
            put(OP_EXPIRE_MS);
            repeat (8) put(8'($urandom));
          end
          default: ;
        endcase
        put((r == bad_rec) ? 8'($urandom_range(1, 255)) : TYPE_STRING);
        put_string();
        put_string();
      end
      // A file without end marker is cut short by the next start of file.
      if (kind != 2) put(OP_EOF);
      repeat ($urandom_range(0, 2)) put(noise_byte());
      if (kind == 3) stim_q[$urandom_range(mark, stim_q.size() - 1)].item.byte_value =
        noise_byte();
    end
    return stim_q.size() - mark;
  endfunction

  // Request driving.
  task automatic send_all();
    int        i;
    int        burst;
    int        gap;
    logic      fire;
    logic      has;
    res_item_t tok;
    i     = 0;
    burst = 0;
    gap   = 0;
    while (i < stim_q.size()) begin
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        gap--;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stim_q[i].item.byte_value;
        s_axis_tuser  <= stim_q[i].item.start_of_file;
      end
      @(negedge clk_i);
      fire = s_axis_tvalid && s_axis_tready;
      @(posedge clk_i);
      if (fire) begin
        has = parse_byte(stim_q[i].item, tok);
        if (stim_q[i].typed) begin
          has = stim_q[i].has_tok;
          tok = stim_q[i].tok;
        end
        if (has) due_tokens.push_back(tok);
        i++;
        if (burst > 0) burst--;
        if (burst == 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst = 64;
            gap   = 0;
          end else begin
            burst = $urandom_range(1, 12);
            gap   = $urandom_range(0, 6);
          end
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    stim_q.delete();
  endtask

  task automatic drain();
    for (int w = 0; w < 5000 && due_tokens.size() != 0; w++) @(posedge clk_i);
    // Trailing bytes without a token may still be in flight.
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_HEADER_LENGTH;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    done = 1'b0;
    while (!done) begin
      @(negedge clk_i);
      done  = pready;
      rdata = prdata;
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_header_length(input logic [7:0] v);
    logic [31:0] rd;
    reg_access(1'b1, 32'(v), rd);
    p_hdr_len = v;
    reg_access(1'b0, '0, rd);
    if (rd !== 32'(v))
      note_fail($sformatf("header length readback: expected %0d, got %0d", v, rd));
  endtask

  // Output check, sampled on the falling edge ahead of the accepting edge.
  always @(negedge clk_i) begin
    res_item_t got;
    res_item_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.token_kind = kind_e'(m_axis_tuser[3:0]);
      got.payload    = m_axis_tdata;
      got.is_integer = m_axis_tuser[4];
      got.field_end  = m_axis_tlast;
      got.is_empty   = m_axis_tuser[5];
      if (due_tokens.size() == 0) begin
        note_fail($sformatf("unexpected token: kind %0d payload %h", got.token_kind,
                            got.payload));
      end else begin
        want = due_tokens.pop_front();
        if (got !== want)
          note_fail($sformatf({"token mismatch (expected/actual): kind %0d/%0d ",
                               "payload %h/%h int %b/%b end %b/%b empty %b/%b"},
                              want.token_kind, got.token_kind, want.payload, got.payload,
                              want.is_integer, got.is_integer, want.field_end,
                              got.field_end, want.is_empty, got.is_empty));
      end
    end
  end

  // Receiver stalls follow a mode picked from the running cycle count.
  always @(posedge clk_i) begin
    case ((cycles / 50) % 4)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (cycles % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [31:0] rd;
    int          hls[6];
    int          body;
    n_fail        = 0;
    next_sof      = 1'b0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    p_hdr_len = HDR_LEN_RESET;
    clear_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    reg_access(1'b0, '0, rd);
    if (rd !== 32'(HDR_LEN_RESET))
      note_fail($sformatf("header length after reset: expected %0d, got %0d",
                          HDR_LEN_RESET, rd));

    // Directed part, no header, so every byte is parsed. The first byte comes
    // without a start of file.
    set_header_length(8'd0);
    row(OP_AUX, 1'b0);
    row_tok(8'h00, 1'b0, 1'b1, K_AUX_KEY, '0, 1'b0, 1'b1, 1'b1);
    row(ENC_INT8, 1'b0);
    row_tok(8'h80, 1'b0, 1'b1, K_AUX_VALUE, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b1, 1'b0);
    row(OP_SELECTDB, 1'b0);
    row_tok(8'h3F, 1'b0, 1'b1, K_DB_INDEX, 64'd63, 1'b1, 1'b1, 1'b0);
    row(OP_RESIZEDB, 1'b0);
    row(8'h7F, 1'b0);
    row_tok(8'hFF, 1'b0, 1'b1, K_KEY_SIZE, 64'h3FFF, 1'b1, 1'b1, 1'b0);
    row(ENC_INT16, 1'b0);
    row(8'hFF, 1'b0);
    row_tok(8'h7F, 1'b0, 1'b1, K_EXP_SIZE, 64'h7FFF, 1'b1, 1'b1, 1'b0);
    row(OP_EXPIRE_S, 1'b0);
    repeat (4) row(8'hFF, 1'b0);
    row(TYPE_STRING, 1'b0);
    row(8'h01, 1'b0);
    row(8'hA5, 1'b0);
    row_tok(8'hC3, 1'b0, 1'b1, K_ERROR, 64'(ERR_STR_ENC), 1'b0, 1'b1, 1'b0);
    row(8'h00, 1'b0);
    row_tok(OP_EOF, 1'b1, 1'b1, K_END, '0, 1'b0, 1'b1, 1'b0);
    row(OP_SELECTDB, 1'b1);
    row_tok(8'hC3, 1'b0, 1'b1, K_ERROR, 64'(ERR_SIZE_ENC), 1'b0, 1'b1, 1'b0);
    row_tok(8'h07, 1'b1, 1'b1, K_ERROR, 64'(ERR_TYPE), 1'b0, 1'b1, 1'b0);
    send_all();

    hls = '{255, 0, 1, 9, 0, 0};
    hls[4] = $urandom_range(2, 40);
    hls[5] = $urandom_range(0, 3);
    foreach (hls[p]) begin
      drain();
      set_header_length(8'(hls[p]));
      body = 0;
      while (body < ((hls[p] == 255) ? 1 : 45)) body += put_file(hls[p]);
      send_all();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (due_tokens.size() != 0)
      note_fail($sformatf("%0d tokens never arrived", due_tokens.size()));
    if (n_fail == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
